// ===== sv/overlap_add_fft_size_chooser_core_defines.svh =====
// Assertion macros shared by the chooser RTL.
`ifndef OVERLAP_ADD_FFT_SIZE_CHOOSER_CORE_DEFINES_SVH
`define OVERLAP_ADD_FFT_SIZE_CHOOSER_CORE_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define OFSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define OFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ofsc_pkg.sv =====
package ofsc_pkg;

    // Field widths of the request and the result.
    localparam int LEN_W    = 24;
    localparam int BLK_W    = 25;
    localparam int STATUS_W = 2;

    // Candidate index, operation-count and cost widths.
    localparam int IDX_W    = 5;
    localparam int OPC_W    = 37;
    localparam int OPC_LO_W = 19;
    localparam int OPC_HI_W = OPC_W - OPC_LO_W;
    localparam int PROD_W   = BLK_W + OPC_LO_W;
    localparam int COST_W   = 62;
    localparam int DCNT_W   = 5;

    // Default parameter values.
    localparam int TABLE_ENTRIES_DEF = 21;
    localparam int LENGTH_BITS_DEF   = 24;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_FILTER   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT_SIGNAL = 2'd2;

    // Divider request and result.
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] dividend;
        logic [BLK_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quot;
        logic             rem_nz;
    } div_res_t;

    // Operation count of a transform of length 2^(idx+1), scaled by 100.
    function automatic logic [OPC_W-1:0] op_cost(input logic [IDX_W-1:0] idx);
        logic [OPC_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 37'd1800;
                5'd1:    val = 37'd5900;
                5'd2:    val = 37'd13800;
                5'd3:    val = 37'd30300;
                5'd4:    val = 37'd66000;
                5'd5:    val = 37'd144100;
                5'd6:    val = 37'd315000;
                5'd7:    val = 37'd687500;
                5'd8:    val = 37'd1495200;
                5'd9:    val = 37'd3237300;
                5'd10:   val = 37'd6976200;
                5'd11:   val = 37'd14964700;
                5'd12:   val = 37'd31964400;
                5'd13:   val = 37'd68010500;
                5'd14:   val = 37'd144197400;
                5'd15:   val = 37'd304761900;
                5'd16:   val = 37'd642273600;
                5'd17:   val = 37'd1350063700;
                5'd18:   val = 37'd2831178600;
                5'd19:   val = 37'd5924479100;
                5'd20:   val = 37'd12382161319;
                5'd21:   val = 37'd25878717156;
                5'd22:   val = 37'd54086518856;
                5'd23:   val = 37'd113040824409;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== sv/ofsc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ofsc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ofsc_pkg::div_req_t req,
    output ofsc_pkg::div_res_t res
);

    localparam int LW = ofsc_pkg::LEN_W;
    localparam int BW = ofsc_pkg::BLK_W;
    localparam int CW = ofsc_pkg::DCNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic [LW-1:0] quo_reg, quo_next;
    logic [BW-1:0] div_reg, div_next;
    logic [BW:0]   shifted;
    logic [BW:0]   diff;
    logic          take;

    // One step: shift in the next dividend bit and subtract when it fits.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[LW-1]};
        diff      = shifted - {1'b0, div_reg};
        take      = (shifted >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = take ? diff[BW-1:0] : shifted[BW-1:0];
            quo_next = {quo_reg[LW-2:0], take};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(LW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign res.done   = done_reg;
    assign res.quot   = quo_reg;
    assign res.rem_nz = |rem_reg;

endmodule

// ===== sv/overlap_add_fft_size_chooser_core.sv =====
// Sequence: an error status goes straight from the request to the result register;
// otherwise each qualifying table length passes through the shared divider, a low
// and a high multiply and a compare, a skipped length only advances the scan, and
// when no length qualifies the next power of two of the signal length is searched.
// Throughput: one request at a time; a new one is taken once the result is queued.
// Reset: rst_n clears the sequencer and the result valid flag asynchronously.
`include "overlap_add_fft_size_chooser_core_defines.svh"

module overlap_add_fft_size_chooser_core #(
    parameter int TABLE_ENTRIES = ofsc_pkg::TABLE_ENTRIES_DEF,
    parameter int LENGTH_BITS   = ofsc_pkg::LENGTH_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ofsc_pkg::LEN_W-1:0]    filter_length,
    input  logic [ofsc_pkg::LEN_W-1:0]    signal_length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ofsc_pkg::BLK_W-1:0]    fft_size,
    output logic [ofsc_pkg::BLK_W-1:0]    block_size,
    output logic [ofsc_pkg::STATUS_W-1:0] status
);

    localparam int LW  = ofsc_pkg::LEN_W;
    localparam int BW  = ofsc_pkg::BLK_W;
    localparam int IW  = ofsc_pkg::IDX_W;
    localparam int CW  = ofsc_pkg::COST_W;
    localparam int PW  = ofsc_pkg::PROD_W;
    localparam int LOW = ofsc_pkg::OPC_LO_W;
    localparam int SW  = ofsc_pkg::STATUS_W;

    localparam logic [LW-1:0] LenMask =
        (LENGTH_BITS >= LW) ? {LW{1'b1}} : LW'((64'd1 << LENGTH_BITS) - 64'd1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MULLO = 3'd3;
    localparam logic [2:0] S_MULHI = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_POW   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic          found_reg, found_next;
    logic          ovalid_reg, ovalid_next;

    logic [LW-1:0] nb_reg, nb_next;
    logic [LW-1:0] nx_reg, nx_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic [BW-1:0] blocks_reg, blocks_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic [PW-1:0] part_reg, part_next;
    logic [CW-1:0] best_cost_reg, best_cost_next;
    logic [BW-1:0] best_len_reg, best_len_next;
    logic [BW-1:0] best_blk_reg, best_blk_next;
    logic [BW-1:0] pow_reg, pow_next;
    logic [BW-1:0] res_len_reg, res_len_next;
    logic [BW-1:0] res_blk_reg, res_blk_next;
    logic [SW-1:0] res_st_reg, res_st_next;
    logic [BW-1:0] fft_reg, fft_next;
    logic [BW-1:0] bsz_reg, bsz_next;
    logic [SW-1:0] st_reg, st_next;

    logic [LW-1:0]  nb_in;
    logic [LW-1:0]  nx_in;
    logic [BW-1:0]  len_cand;
    logic [BW-1:0]  blk_cand;
    logic           qualifies;
    logic [ofsc_pkg::OPC_W-1:0] opc;
    logic [LOW-1:0] mul_b;
    logic [PW-1:0]  product;
    logic [CW-1:0]  cost_sum;
    logic           in_take;
    logic           out_free;

    ofsc_pkg::div_req_t div_req;
    ofsc_pkg::div_res_t div_res;

    ofsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    // Candidate length and its block length.
    assign nb_in     = filter_length & LenMask;
    assign nx_in     = signal_length & LenMask;
    assign len_cand  = BW'(2) << idx_reg;
    assign qualifies = (len_cand >= {1'b0, nb_reg});
    assign blk_cand  = len_cand - {1'b0, nb_reg} + BW'(1);

    // Shared multiplier: block count times one half of the operation count.
    assign opc      = ofsc_pkg::op_cost(idx_reg);
    assign mul_b    = (state_reg == S_MULHI) ? LOW'(opc[ofsc_pkg::OPC_W-1:LOW])
                                             : opc[LOW-1:0];
    assign product  = PW'(blocks_reg) * PW'(mul_b);
    assign cost_sum = acc_reg + (CW'(part_reg) << LOW);

    assign in_take  = in_valid && !in_stall;
    assign out_free = !ovalid_reg || !out_stall;

    // Divider start as a candidate qualifies.
    always_comb
    begin
        div_req.start    = (state_reg == S_SCAN) && (idx_reg != IW'(TABLE_ENTRIES))
                           && qualifies;
        div_req.dividend = nx_reg;
        div_req.divisor  = blk_cand;
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        found_next     = found_reg;
        ovalid_next    = ovalid_reg;
        nb_next        = nb_reg;
        nx_next        = nx_reg;
        idx_next       = idx_reg;
        blk_next       = blk_reg;
        blocks_next    = blocks_reg;
        acc_next       = acc_reg;
        part_next      = part_reg;
        best_cost_next = best_cost_reg;
        best_len_next  = best_len_reg;
        best_blk_next  = best_blk_reg;
        pow_next       = pow_reg;
        res_len_next   = res_len_reg;
        res_blk_next   = res_blk_reg;
        res_st_next    = res_st_reg;
        fft_next       = fft_reg;
        bsz_next       = bsz_reg;
        st_next        = st_reg;

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    nb_next    = nb_in;
                    nx_next    = nx_in;
                    idx_next   = '0;
                    found_next = 1'b0;
                    res_len_next = '0;
                    res_blk_next = '0;
                    if (nb_in == '0)
                    begin
                        res_st_next = ofsc_pkg::ST_BAD_FILTER;
                        state_next  = S_FIN;
                    end
                    else if (nx_in <= nb_in)
                    begin
                        res_st_next = ofsc_pkg::ST_SHORT_SIGNAL;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        res_st_next = ofsc_pkg::ST_OK;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg == IW'(TABLE_ENTRIES))
                begin
                    if (found_reg)
                    begin
                        res_len_next = best_len_reg;
                        res_blk_next = best_blk_reg;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        pow_next   = BW'(1);
                        state_next = S_POW;
                    end
                end
                else if (qualifies)
                begin
                    blk_next   = blk_cand;
                    state_next = S_DIV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    blocks_next = BW'(div_res.quot) + BW'(div_res.rem_nz);
                    state_next  = S_MULLO;
                end
            end
            S_MULLO:
            begin
                acc_next   = CW'(product);
                state_next = S_MULHI;
            end
            S_MULHI:
            begin
                part_next  = product;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // The earlier candidate keeps a tie.
                if (!found_reg || (cost_sum < best_cost_reg))
                begin
                    found_next     = 1'b1;
                    best_cost_next = cost_sum;
                    best_len_next  = len_cand;
                    best_blk_next  = blk_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_POW:
            begin
                if (pow_reg < BW'(nx_reg))
                begin
                    pow_next = pow_reg << 1;
                end
                else
                begin
                    res_len_next = pow_reg;
                    res_blk_next = pow_reg - BW'(nb_reg) + BW'(1);
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    fft_next    = res_len_reg;
                    bsz_next    = res_blk_reg;
                    st_next     = res_st_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        nb_reg        <= nb_next;
        nx_reg        <= nx_next;
        idx_reg       <= idx_next;
        blk_reg       <= blk_next;
        blocks_reg    <= blocks_next;
        acc_reg       <= acc_next;
        part_reg      <= part_next;
        best_cost_reg <= best_cost_next;
        best_len_reg  <= best_len_next;
        best_blk_reg  <= best_blk_next;
        pow_reg       <= pow_next;
        res_len_reg   <= res_len_next;
        res_blk_reg   <= res_blk_next;
        res_st_reg    <= res_st_next;
        fft_reg       <= fft_next;
        bsz_reg       <= bsz_next;
        st_reg        <= st_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = ovalid_reg;
    assign fft_size   = fft_reg;
    assign block_size = bsz_reg;
    assign status     = st_reg;

    // Checks on the sequencer and the result.
    `OFSC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take,
        state_reg != S_IDLE, "request taken but sequencer stayed idle")
    `OFSC_ASSERT_SAME(a_error_zeroes, clk, rst_n, ovalid_reg && (st_reg != ofsc_pkg::ST_OK),
        (fft_reg == '0) && (bsz_reg == '0), "error result carries nonzero sizes")
    `OFSC_ASSERT_SAME(a_ok_pow2, clk, rst_n, ovalid_reg && (st_reg == ofsc_pkg::ST_OK),
        $onehot(fft_reg) && (bsz_reg != '0) && (bsz_reg <= fft_reg),
        "ok result has a bad transform or block size")

endmodule
